// ===== hw/rtl/etrs_pkg.sv =====
// Shared types, constants and fixed-point helpers for the Euler TRS matrix builder.
// No dependencies; every other file of the block refers to it by scoped names.
`default_nettype none

package etrs_pkg;

   typedef struct packed {
      logic signed [31:0] trans_x;
      logic signed [31:0] trans_y;
      logic signed [31:0] trans_z;
      logic signed [31:0] angle_x;
      logic signed [31:0] angle_y;
      logic signed [31:0] angle_z;
      logic signed [31:0] scale_x;
      logic signed [31:0] scale_y;
      logic signed [31:0] scale_z;
   } req_type;

   typedef struct packed {
      logic signed [31:0] m00;
      logic signed [31:0] m01;
      logic signed [31:0] m02;
      logic signed [31:0] m10;
      logic signed [31:0] m11;
      logic signed [31:0] m12;
      logic signed [31:0] m20;
      logic signed [31:0] m21;
      logic signed [31:0] m22;
      logic signed [31:0] col3_x;
      logic signed [31:0] col3_y;
      logic signed [31:0] col3_z;
   } rsp_type;

   // Angle reduction constants (degrees in Q16.16).
   localparam logic [25:0] TURN_Q16    = 26'd23592960;
   localparam logic [22:0] QUARTER_Q16 = 23'd5898240;
   localparam logic [19:0] WRAP_OFFSET = 20'd524288;   // 2^31 mod one turn
   localparam logic [15:0] TURN_RECIP  = 16'd46603;    // floor(2^40 / turn)
   localparam logic [31:0] PI_Q30      = 32'hC90FDAA2;
   localparam logic [31:0] RECIP_45    = 32'd3054198966; // floor(2^37 / 45)
   localparam logic [5:0]  DIV_45      = 6'd45;

   localparam int CORDIC_STEPS = 30;
   localparam int PREP_LAT     = 6;
   localparam int CORDIC_LAT   = CORDIC_STEPS + 1;
   localparam int MATRIX_LAT   = 5;
   localparam int SIDE_LAT     = PREP_LAT + CORDIC_LAT;
   localparam int TOTAL_LAT    = SIDE_LAT + MATRIX_LAT;

   localparam logic signed [33:0] CORDIC_GAIN = 34'sd652032874;

   function automatic logic signed [33:0] atan_q30(input logic [4:0] idx);
      logic signed [33:0] v;
      unique case (idx)
         5'd0:  v = 34'sh3243F6A8;
         5'd1:  v = 34'sh1DAC6705;
         5'd2:  v = 34'sh0FADBAFC;
         5'd3:  v = 34'sh07F56EA6;
         5'd4:  v = 34'sh03FEAB76;
         5'd5:  v = 34'sh01FFD55B;
         5'd6:  v = 34'sh00FFFAAA;
         5'd7:  v = 34'sh007FFF55;
         5'd8:  v = 34'sh003FFFEA;
         5'd9:  v = 34'sh001FFFFD;
         5'd10: v = 34'sh000FFFFF;
         5'd11: v = 34'sh0007FFFF;
         5'd12: v = 34'sh0003FFFF;
         5'd13: v = 34'sh0001FFFF;
         5'd14: v = 34'sh0000FFFF;
         5'd15: v = 34'sh00007FFF;
         5'd16: v = 34'sh00003FFF;
         5'd17: v = 34'sh00001FFF;
         5'd18: v = 34'sh00000FFF;
         5'd19: v = 34'sh000007FF;
         5'd20: v = 34'sh000003FF;
         5'd21: v = 34'sh000001FF;
         5'd22: v = 34'sh000000FF;
         5'd23: v = 34'sh0000007F;
         5'd24: v = 34'sh0000003F;
         5'd25: v = 34'sh0000001F;
         5'd26: v = 34'sh0000000F;
         5'd27: v = 34'sh00000008;
         5'd28: v = 34'sh00000004;
         5'd29: v = 34'sh00000002;
         default: v = 34'sh00000000;
      endcase
      return v;
   endfunction

   // Q2.30 product, rounded half up by adding 2^29 and flooring.
   function automatic logic signed [33:0] mul_q30(input logic signed [33:0] a,
                                                  input logic signed [33:0] b);
      logic signed [67:0] p;
      p = 68'(a) * 68'(b) + 68'sd536870912;
      return p[63:30];
   endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/etrs_angle_prep.sv =====
// Angle reduction: wraps a Q16.16 degree angle into one turn, splits off the
// quadrant and converts the remainder to Q2.30 radians. Uses etrs_pkg.
`default_nettype none

module etrs_angle_prep (
   input  wire logic               clock,
   input  wire logic               advance,
   input  wire logic signed [31:0] angle,
   output logic              [1:0] quad,
   output logic             [30:0] theta
);

   logic [31:0] u1_ff;
   logic [7:0]  qe1_ff;
   logic [24:0] r2_ff;
   logic [1:0]  q3_ff, q4_ff, q5_ff, q6_ff;
   logic [22:0] f3_ff;
   logic [36:0] t4_ff, t5_ff;
   logic [31:0] est5_ff;
   logic [30:0] z6_ff;

   logic [31:0] u1_in;
   logic [47:0] qprod;
   logic [32:0] ra, rb;
   logic signed [26:0] rc;
   logic [24:0] r2_in;
   logic [1:0]  q3_in;
   logic [22:0] f3_in;
   logic [54:0] pprod;
   logic [63:0] eprod;
   logic [36:0] rem;
   logic [30:0] z6_in;

   always_comb begin
      // Offset by 2^31 so the reduction works on an unsigned value.
      u1_in = {~angle[31], angle[30:0]};
      qprod = 48'(u1_in) * 48'(etrs_pkg::TURN_RECIP);

      ra = {1'b0, u1_ff} - 33'(qe1_ff) * 33'(etrs_pkg::TURN_Q16);
      rb = (ra >= 33'(etrs_pkg::TURN_Q16)) ? ra - 33'(etrs_pkg::TURN_Q16) : ra;
      rc = $signed({1'b0, rb[25:0]}) - $signed(27'(etrs_pkg::WRAP_OFFSET));
      if (rc < 0) begin
         rc = rc + $signed(27'(etrs_pkg::TURN_Q16));
      end
      r2_in = rc[24:0];

      if (r2_ff >= 25'(3) * 25'(etrs_pkg::QUARTER_Q16)) begin
         q3_in = 2'd3;
      end else if (r2_ff >= 25'(2) * 25'(etrs_pkg::QUARTER_Q16)) begin
         q3_in = 2'd2;
      end else if (r2_ff >= 25'(etrs_pkg::QUARTER_Q16)) begin
         q3_in = 2'd1;
      end else begin
         q3_in = 2'd0;
      end
      f3_in = 23'(r2_ff - 25'(q3_in) * 25'(etrs_pkg::QUARTER_Q16));

      pprod = 55'(f3_ff) * 55'(etrs_pkg::PI_Q30);
      eprod = 64'(t4_ff[36:5]) * 64'(etrs_pkg::RECIP_45);

      // The estimate is low by at most two; one look at the remainder fixes it.
      rem = t5_ff - 37'(est5_ff) * 37'(etrs_pkg::DIV_45);
      if (rem >= 37'(2) * 37'(etrs_pkg::DIV_45)) begin
         z6_in = 31'(est5_ff) + 31'd2;
      end else if (rem >= 37'(etrs_pkg::DIV_45)) begin
         z6_in = 31'(est5_ff) + 31'd1;
      end else begin
         z6_in = 31'(est5_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         u1_ff   <= u1_in;
         qe1_ff  <= qprod[47:40];
         r2_ff   <= r2_in;
         q3_ff   <= q3_in;
         f3_ff   <= f3_in;
         q4_ff   <= q3_ff;
         t4_ff   <= pprod[54:18];
         q5_ff   <= q4_ff;
         t5_ff   <= t4_ff;
         est5_ff <= eprod[63:32];
         q6_ff   <= q5_ff;
         z6_ff   <= z6_in;
      end
   end

   assign quad  = q6_ff;
   assign theta = z6_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/etrs_cordic.sv =====
// Unrolled rotation-mode CORDIC, one iteration per register stage, followed by
// the quadrant mapping to cosine and sine. Uses etrs_pkg.
`default_nettype none

module etrs_cordic (
   input  wire logic               clock,
   input  wire logic               advance,
   input  wire logic         [1:0] quad,
   input  wire logic        [30:0] theta,
   output logic signed      [33:0] cos_q30,
   output logic signed      [33:0] sin_q30
);

   localparam int N = etrs_pkg::CORDIC_STEPS;

   logic signed [33:0] x_ff [0:N-1];
   logic signed [33:0] y_ff [0:N-1];
   logic signed [33:0] z_ff [0:N-1];
   logic        [1:0]  q_ff [0:N-1];
   logic signed [33:0] x_in [0:N-1];
   logic signed [33:0] y_in [0:N-1];
   logic signed [33:0] z_in [0:N-1];
   logic        [1:0]  q_in [0:N-1];
   logic signed [33:0] cos_ff, sin_ff, cos_in, sin_in;

   always_comb begin
      logic signed [33:0] xs, ys, zs;
      for (int i = 0; i < N; i++) begin
         if (i == 0) begin
            xs      = etrs_pkg::CORDIC_GAIN;
            ys      = '0;
            zs      = $signed({3'b000, theta});
            q_in[i] = quad;
         end else begin
            xs      = x_ff[i-1];
            ys      = y_ff[i-1];
            zs      = z_ff[i-1];
            q_in[i] = q_ff[i-1];
         end
         if (!zs[33]) begin
            x_in[i] = xs - (ys >>> i);
            y_in[i] = ys + (xs >>> i);
            z_in[i] = zs - etrs_pkg::atan_q30(5'(i));
         end else begin
            x_in[i] = xs + (ys >>> i);
            y_in[i] = ys - (xs >>> i);
            z_in[i] = zs + etrs_pkg::atan_q30(5'(i));
         end
      end

      unique case (q_ff[N-1])
         2'd0: begin cos_in =  x_ff[N-1]; sin_in =  y_ff[N-1]; end
         2'd1: begin cos_in = -y_ff[N-1]; sin_in =  x_ff[N-1]; end
         2'd2: begin cos_in = -x_ff[N-1]; sin_in = -y_ff[N-1]; end
         default: begin cos_in = y_ff[N-1]; sin_in = -x_ff[N-1]; end
      endcase
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int i = 0; i < N; i++) begin
            x_ff[i] <= x_in[i];
            y_ff[i] <= y_in[i];
            z_ff[i] <= z_in[i];
            q_ff[i] <= q_in[i];
         end
         cos_ff <= cos_in;
         sin_ff <= sin_in;
      end
   end

   assign cos_q30 = cos_ff;
   assign sin_q30 = sin_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/etrs_matrix.sv =====
// Rotation products, per-row scaling and saturation into the result struct.
// Five register stages; uses etrs_pkg types and the Q2.30 product helper.
`default_nettype none

module etrs_matrix (
   input  wire logic               clock,
   input  wire logic               advance,
   input  wire logic signed [33:0] cx,
   input  wire logic signed [33:0] sx,
   input  wire logic signed [33:0] cy,
   input  wire logic signed [33:0] sy,
   input  wire logic signed [33:0] cz,
   input  wire logic signed [33:0] sz,
   input  wire etrs_pkg::req_type  side,
   output etrs_pkg::rsp_type       result
);

   // Stage 1: pairwise products.
   logic signed [33:0] sxsy1_ff, cxsy1_ff, cycz1_ff, cysz1_ff, cxsz1_ff;
   logic signed [33:0] cxcz1_ff, sxcy1_ff, sxsz1_ff, sxcz1_ff, cxcy1_ff;
   logic signed [33:0] cz1_ff, sz1_ff, sy1_ff;
   // Stage 2: triple products.
   logic signed [33:0] sxsycz2_ff, sxsysz2_ff, cxsycz2_ff, cxsysz2_ff;
   logic signed [33:0] cycz2_ff, cysz2_ff, cxsz2_ff, cxcz2_ff;
   logic signed [33:0] sxcy2_ff, sxsz2_ff, sxcz2_ff, cxcy2_ff, sy2_ff;
   // Stage 3: rotation entries; stage 4: scaled; stage 5: saturated.
   logic signed [34:0] rot3_ff [0:8];
   logic signed [34:0] rot3_in [0:8];
   logic signed [36:0] scl4_ff [0:8];
   logic signed [36:0] scl4_in [0:8];
   logic signed [31:0] sat5_in [0:8];
   etrs_pkg::req_type  side1_ff, side2_ff, side3_ff, side4_ff;
   etrs_pkg::rsp_type  out5_ff;

   always_comb begin
      logic signed [66:0] p;
      logic signed [31:0] sc;
      rot3_in[0] = 35'(cycz2_ff);
      rot3_in[1] = -35'(cysz2_ff);
      rot3_in[2] = 35'(sy2_ff);
      rot3_in[3] = 35'(sxsycz2_ff) + 35'(cxsz2_ff);
      rot3_in[4] = 35'(cxcz2_ff) - 35'(sxsysz2_ff);
      rot3_in[5] = -35'(sxcy2_ff);
      rot3_in[6] = 35'(sxsz2_ff) - 35'(cxsycz2_ff);
      rot3_in[7] = 35'(cxsysz2_ff) + 35'(sxcz2_ff);
      rot3_in[8] = 35'(cxcy2_ff);
      for (int k = 0; k < 9; k++) begin
         sc = (k < 3) ? side3_ff.scale_x : (k < 6) ? side3_ff.scale_y : side3_ff.scale_z;
         p = 67'(rot3_ff[k]) * 67'(sc) + 67'sd536870912;
         scl4_in[k] = p[66:30];
         if (scl4_ff[k][36:31] == {6{scl4_ff[k][31]}}) begin
            sat5_in[k] = scl4_ff[k][31:0];
         end else if (scl4_ff[k][36]) begin
            sat5_in[k] = 32'sh80000000;
         end else begin
            sat5_in[k] = 32'sh7FFFFFFF;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         sxsy1_ff <= etrs_pkg::mul_q30(sx, sy);
         cxsy1_ff <= etrs_pkg::mul_q30(cx, sy);
         cycz1_ff <= etrs_pkg::mul_q30(cy, cz);
         cysz1_ff <= etrs_pkg::mul_q30(cy, sz);
         cxsz1_ff <= etrs_pkg::mul_q30(cx, sz);
         cxcz1_ff <= etrs_pkg::mul_q30(cx, cz);
         sxcy1_ff <= etrs_pkg::mul_q30(sx, cy);
         sxsz1_ff <= etrs_pkg::mul_q30(sx, sz);
         sxcz1_ff <= etrs_pkg::mul_q30(sx, cz);
         cxcy1_ff <= etrs_pkg::mul_q30(cx, cy);
         cz1_ff   <= cz;
         sz1_ff   <= sz;
         sy1_ff   <= sy;
         side1_ff <= side;

         sxsycz2_ff <= etrs_pkg::mul_q30(sxsy1_ff, cz1_ff);
         sxsysz2_ff <= etrs_pkg::mul_q30(sxsy1_ff, sz1_ff);
         cxsycz2_ff <= etrs_pkg::mul_q30(cxsy1_ff, cz1_ff);
         cxsysz2_ff <= etrs_pkg::mul_q30(cxsy1_ff, sz1_ff);
         cycz2_ff   <= cycz1_ff;
         cysz2_ff   <= cysz1_ff;
         cxsz2_ff   <= cxsz1_ff;
         cxcz2_ff   <= cxcz1_ff;
         sxcy2_ff   <= sxcy1_ff;
         sxsz2_ff   <= sxsz1_ff;
         sxcz2_ff   <= sxcz1_ff;
         cxcy2_ff   <= cxcy1_ff;
         sy2_ff     <= sy1_ff;
         side2_ff   <= side1_ff;

         for (int k = 0; k < 9; k++) begin
            rot3_ff[k] <= rot3_in[k];
            scl4_ff[k] <= scl4_in[k];
         end
         side3_ff <= side2_ff;
         side4_ff <= side3_ff;

         out5_ff.m00    <= sat5_in[0];
         out5_ff.m01    <= sat5_in[1];
         out5_ff.m02    <= sat5_in[2];
         out5_ff.m10    <= sat5_in[3];
         out5_ff.m11    <= sat5_in[4];
         out5_ff.m12    <= sat5_in[5];
         out5_ff.m20    <= sat5_in[6];
         out5_ff.m21    <= sat5_in[7];
         out5_ff.m22    <= sat5_in[8];
         out5_ff.col3_x <= side4_ff.trans_x;
         out5_ff.col3_y <= side4_ff.trans_y;
         out5_ff.col3_z <= side4_ff.trans_z;
      end
   end

   assign result = out5_ff;

endmodule

`default_nettype wire

// ===== hw/rtl/euler_trs_matrix_builder.sv =====
// Top level of the Euler TRS matrix builder: angle preparation, CORDIC and
// matrix stages under one pipeline enable. Uses etrs_pkg and all etrs_ modules.
//
//   channel   direction   ports                                  carries
//   req       in          req_valid, req_ready, req_data         etrs_pkg::req_type
//   rsp       out         rsp_valid, rsp_ready, rsp_data         etrs_pkg::rsp_type
//
// One item per cycle enters while rsp is not stalled; each result passes through
// 6 angle reduction stages, 30 CORDIC iterations plus quadrant mapping, and 5 matrix stages.
// The whole pipeline advances as one whenever the output register is empty or drained,
// so a stall on rsp holds every stage in place and req_ready drops with it.
// Synchronous reset clears only the valid bits; data registers carry no reset.
`default_nettype none

module euler_trs_matrix_builder (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire etrs_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output etrs_pkg::rsp_type      rsp_data
);

   localparam int SL = etrs_pkg::SIDE_LAT;
   localparam int TL = etrs_pkg::TOTAL_LAT;

   logic [TL-1:0]      vld_ff;
   logic [TL-1:0]      vld_in;
   etrs_pkg::req_type  side_ff [0:SL-1];
   logic               advance;

   logic [1:0]         qx, qy, qz;
   logic [30:0]        tx, ty, tz;
   logic signed [33:0] cx, sx, cy, sy, cz, sz;

   assign advance   = !vld_ff[TL-1] || rsp_ready;
   assign req_ready = advance;
   assign rsp_valid = vld_ff[TL-1];
   assign vld_in    = {vld_ff[TL-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= vld_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         side_ff[0] <= req_data;
         for (int i = 1; i < SL; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end

   etrs_angle_prep u_prep_x (.clock(clock), .advance(advance), .angle(req_data.angle_x),
                             .quad(qx), .theta(tx));
   etrs_angle_prep u_prep_y (.clock(clock), .advance(advance), .angle(req_data.angle_y),
                             .quad(qy), .theta(ty));
   etrs_angle_prep u_prep_z (.clock(clock), .advance(advance), .angle(req_data.angle_z),
                             .quad(qz), .theta(tz));

   etrs_cordic u_cordic_x (.clock(clock), .advance(advance), .quad(qx), .theta(tx),
                           .cos_q30(cx), .sin_q30(sx));
   etrs_cordic u_cordic_y (.clock(clock), .advance(advance), .quad(qy), .theta(ty),
                           .cos_q30(cy), .sin_q30(sy));
   etrs_cordic u_cordic_z (.clock(clock), .advance(advance), .quad(qz), .theta(tz),
                           .cos_q30(cz), .sin_q30(sz));

   etrs_matrix u_matrix (
      .clock   (clock),
      .advance (advance),
      .cx      (cx),
      .sx      (sx),
      .cy      (cy),
      .sy      (sy),
      .cz      (cz),
      .sz      (sz),
      .side    (side_ff[SL-1]),
      .result  (rsp_data)
   );

   // A transfer on req always lands in the first valid stage.
   a_req_enters: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> vld_ff[0])
      else $error("accepted request did not enter the pipeline");

   // While the output stalls, no stage moves.
   a_stall_holds: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(vld_ff))
      else $error("pipeline moved during an output stall");

   // The pipeline is empty right after reset.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> (vld_ff == '0))
      else $error("valid bits survived reset");

endmodule

`default_nettype wire
